// ----- hw/rtl/rafc_pkg.sv -----
// Shared types, constants and fixed-point helpers for the rotational anisotropy field core.
`default_nettype none

package rafc_pkg;

  // Pipeline depth: table read, twelve arithmetic stages, output register
  localparam int NS = 14;
  localparam int MATERIALS_DEF = 16;

  // Request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_FIELD  = 2'd1;
  localparam logic [1:0] REQ_ENERGY = 2'd2;

  // Coefficient slots
  localparam logic [2:0] SLOT_AXES_END = 3'd6;  // slots below this hold axis components
  localparam logic [2:0] SLOT_CONST    = 3'd6;

  // Q.30 fractions, rounded to nearest
  localparam logic signed [33:0] C32_11 = 34'sd3123612579;
  localparam logic signed [33:0] C16_11 = 34'sd1561806289;
  localparam logic signed [33:0] C16_33 = 34'sd520602096;
  localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

  localparam logic signed [57:0] MAX48 = 58'sd140737488355327;
  localparam logic signed [57:0] MIN48 = -58'sd140737488355328;

  typedef struct packed {
    logic               is_energy;
    logic signed [47:0] base_x;
    logic signed [47:0] base_y;
    logic signed [47:0] base_z;
  } ctx_t;

  typedef struct packed {
    logic signed [31:0] f_x;
    logic signed [31:0] f_y;
    logic signed [31:0] f_z;
    logic signed [31:0] g_x;
    logic signed [31:0] g_y;
    logic signed [31:0] g_z;
    logic signed [47:0] k;
  } coef_t;

  typedef struct packed {
    ctx_t  ctx;
    coef_t coef;
  } side_t;

  // Projection results handed to the polynomial stages
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sx2;
    logic signed [31:0] sy2;
    logic signed [32:0] t;
    logic signed [33:0] a1;   // 3*sx2 - sy2
    logic signed [33:0] b1;   // sx2 - 3*sy2
    logic signed [31:0] d;    // sx2 - sy2
  } proj_t;

  typedef struct packed {
    logic signed [36:0] px;
    logic signed [36:0] py;
    logic signed [36:0] he;   // poly * (sx2 - sy2)
  } poly_t;

  // Shift right by 30, truncating toward zero
  function automatic logic signed [65:0] q30(input logic signed [95:0] p);
    logic signed [95:0] adj;
    adj = p[95] ? p + 96'sd1073741823 : p;
    return $signed(adj[95:30]);
  endfunction

  function automatic logic signed [65:0] mulq(input logic signed [47:0] a,
                                              input logic signed [47:0] b);
    logic signed [95:0] p;
    p = 96'(a) * 96'(b);
    return q30(p);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [57:0] v);
    logic signed [47:0] r;
    if (v > MAX48) r = MAX48[47:0];
    else if (v < MIN48) r = MIN48[47:0];
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7fffffff;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rafc_if.sv -----
// Valid/ready channel interfaces for request items and result items.
`default_nettype none

interface rafc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [3:0]         material;
  logic [2:0]         table_slot;
  logic signed [47:0] table_value;
  logic signed [31:0] spin_x;
  logic signed [31:0] spin_y;
  logic signed [31:0] spin_z;
  logic signed [47:0] base_x;
  logic signed [47:0] base_y;
  logic signed [47:0] base_z;

  modport source (output valid, req_type, material, table_slot, table_value,
                  spin_x, spin_y, spin_z, base_x, base_y, base_z, input ready);
  modport sink (input valid, req_type, material, table_slot, table_value,
                spin_x, spin_y, spin_z, base_x, base_y, base_z, output ready);
endinterface

interface rafc_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] field_x;
  logic signed [47:0] field_y;
  logic signed [47:0] field_z;
  logic signed [47:0] energy;

  modport source (output valid, field_x, field_y, field_z, energy, input ready);
  modport sink (input valid, field_x, field_y, field_z, energy, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rafc_ctrl.sv -----
// Pipeline valid chain and per-stage advance enables.
`default_nettype none

module rafc_ctrl import rafc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_compute,
  input  logic          out_ready,
  output logic [NS-1:0] en,
  output logic          in_ready,
  output logic          out_valid
);

  logic [NS-1:0] v_r;

  // A stage may load when it is empty or its contents move on
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS-2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid && in_compute;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/rafc_table.sv -----
// Per-material axis and constant memories with registered read.
`default_nettype none

module rafc_table import rafc_pkg::*; #(
  parameter int MATERIALS = MATERIALS_DEF
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic               rd_en,
  input  logic [3:0]         material,
  input  logic [2:0]         slot,
  input  logic signed [47:0] value,
  output coef_t              coef
);

  localparam int AW = (MATERIALS > 1) ? $clog2(MATERIALS) : 1;

  logic [31:0] ax_mem [6][MATERIALS];
  logic [47:0] k_mem [MATERIALS];

  logic [7:0]    mat8;
  logic [AW-1:0] idx;
  logic          mat_ok;
  logic [31:0]   ax_rd_r [6];
  logic [47:0]   k_rd_r;
  logic          ok_r;

  assign mat8   = {4'b0, material};
  assign idx    = mat8[AW-1:0];
  assign mat_ok = 9'(material) < 9'(MATERIALS);

  // Load items write one coefficient
  always_ff @(posedge clk) begin
    if (wr_en && mat_ok) begin
      if (slot < SLOT_AXES_END) ax_mem[slot][idx] <= sat32(value);
      else if (slot == SLOT_CONST) k_mem[idx] <= value;
    end
  end

  // Registered read for the item entering the pipeline
  always_ff @(posedge clk) begin
    if (rd_en) begin
      for (int i = 0; i < 6; i++) ax_rd_r[i] <= ax_mem[i][idx];
      k_rd_r <= k_mem[idx];
      ok_r   <= mat_ok;
    end
  end

  // Out-of-range material reads as a zero entry
  always_comb begin
    coef.f_x = ok_r ? $signed(ax_rd_r[0]) : '0;
    coef.f_y = ok_r ? $signed(ax_rd_r[1]) : '0;
    coef.f_z = ok_r ? $signed(ax_rd_r[2]) : '0;
    coef.g_x = ok_r ? $signed(ax_rd_r[3]) : '0;
    coef.g_y = ok_r ? $signed(ax_rd_r[4]) : '0;
    coef.g_z = ok_r ? $signed(ax_rd_r[5]) : '0;
    coef.k   = ok_r ? $signed(k_rd_r) : '0;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rafc_proj.sv -----
// Projection of the spin onto both axes, squares and sums (four stages).
`default_nettype none

module rafc_proj import rafc_pkg::*; (
  input  logic               clk,
  input  logic [3:0]         en,
  input  logic signed [31:0] spin_x,
  input  logic signed [31:0] spin_y,
  input  logic signed [31:0] spin_z,
  input  coef_t              coef,
  output proj_t              proj
);

  logic signed [33:0] pf_r [3];
  logic signed [33:0] pg_r [3];
  logic signed [31:0] sx_c_r, sy_c_r;
  logic signed [31:0] sx_d_r, sy_d_r, sx2_r, sy2_r;
  proj_t              proj_r;
  logic signed [35:0] sum_f, sum_g;
  logic signed [65:0] mf [3];
  logic signed [65:0] mg [3];
  logic signed [65:0] msx, msy;

  // Stage 1: six component products
  always_comb begin
    mf[0] = mulq(48'(spin_x), 48'(coef.f_x));
    mf[1] = mulq(48'(spin_y), 48'(coef.f_y));
    mf[2] = mulq(48'(spin_z), 48'(coef.f_z));
    mg[0] = mulq(48'(spin_x), 48'(coef.g_x));
    mg[1] = mulq(48'(spin_y), 48'(coef.g_y));
    mg[2] = mulq(48'(spin_z), 48'(coef.g_z));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        pf_r[i] <= mf[i][33:0];
        pg_r[i] <= mg[i][33:0];
      end
    end
  end

  // Stage 2: dot products, clamped to unit range
  always_comb begin
    sum_f = 36'(pf_r[0]) + 36'(pf_r[1]) + 36'(pf_r[2]);
    sum_g = 36'(pg_r[0]) + 36'(pg_r[1]) + 36'(pg_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (sum_f > 36'(Q30_ONE)) sx_c_r <= Q30_ONE;
      else if (sum_f < -36'(Q30_ONE)) sx_c_r <= -Q30_ONE;
      else sx_c_r <= sum_f[31:0];
      if (sum_g > 36'(Q30_ONE)) sy_c_r <= Q30_ONE;
      else if (sum_g < -36'(Q30_ONE)) sy_c_r <= -Q30_ONE;
      else sy_c_r <= sum_g[31:0];
    end
  end

  // Stage 3: squares
  assign msx = mulq(48'(sx_c_r), 48'(sx_c_r));
  assign msy = mulq(48'(sy_c_r), 48'(sy_c_r));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sx_d_r <= sx_c_r;
      sy_d_r <= sy_c_r;
      sx2_r  <= msx[31:0];
      sy2_r  <= msy[31:0];
    end
  end

  // Stage 4: sums and differences of the squares
  always_ff @(posedge clk) begin
    if (en[3]) begin
      proj_r.sx  <= sx_d_r;
      proj_r.sy  <= sy_d_r;
      proj_r.sx2 <= sx2_r;
      proj_r.sy2 <= sy2_r;
      proj_r.t   <= 33'(sx2_r) + 33'(sy2_r);
      proj_r.a1  <= (34'(sx2_r) <<< 1) + 34'(sx2_r) - 34'(sy2_r);
      proj_r.b1  <= 34'(sx2_r) - (34'(sy2_r) <<< 1) - 34'(sy2_r);
      proj_r.d   <= sx2_r - sy2_r;
    end
  end

  assign proj = proj_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rafc_poly.sv -----
// Field and energy polynomials in the two projections (four stages).
`default_nettype none

module rafc_poly import rafc_pkg::*; (
  input  logic       clk,
  input  logic [3:0] en,
  input  proj_t      proj,
  output poly_t      poly
);

  // stage F
  logic signed [32:0] m1_r, m4_r;
  logic signed [33:0] m2_r, m3_r, e1_r, e2_r;
  logic signed [31:0] sx_f_r, sy_f_r, d_f_r;
  logic signed [33:0] a1_f_r, b1_f_r;
  // stage G
  logic signed [34:0] q1_r, q2_r;
  logic signed [35:0] pe_r;
  logic signed [32:0] m1_g_r, m4_g_r;
  logic signed [31:0] sx_g_r, sy_g_r, d_g_r;
  logic signed [33:0] a1_g_r, b1_g_r;
  // stage H
  logic signed [35:0] h1_r, h2_r, h3_r, h4_r, he_r;
  poly_t              poly_r;

  logic signed [65:0] w1, w2, w3, w4, w5, w6;
  logic signed [65:0] x1, x2, x3, x4, x5;

  // Stage F: products with t and the scaled squares
  always_comb begin
    w1 = mulq(48'(proj.sx), 48'(proj.t));
    w2 = mulq(48'(C32_11), 48'(proj.sx2));
    w3 = mulq(48'(C32_11), 48'(proj.sy2));
    w4 = mulq(48'(proj.sy), 48'(proj.t));
    w5 = mulq(48'(proj.t), 48'(proj.t));
    w6 = mulq(48'(C16_11), 48'(proj.t));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m1_r   <= w1[32:0];
      m2_r   <= w2[33:0];
      m3_r   <= w3[33:0];
      m4_r   <= w4[32:0];
      e1_r   <= w5[33:0];
      e2_r   <= w6[33:0];
      sx_f_r <= proj.sx;
      sy_f_r <= proj.sy;
      d_f_r  <= proj.d;
      a1_f_r <= proj.a1;
      b1_f_r <= proj.b1;
    end
  end

  // Stage G: offsets
  always_ff @(posedge clk) begin
    if (en[1]) begin
      q1_r   <= 35'(m2_r) - 35'(C16_33);
      q2_r   <= 35'(m3_r) - 35'(C16_33);
      pe_r   <= 36'(e1_r) - 36'(e2_r) + 36'(C16_33);
      m1_g_r <= m1_r;
      m4_g_r <= m4_r;
      sx_g_r <= sx_f_r;
      sy_g_r <= sy_f_r;
      d_g_r  <= d_f_r;
      a1_g_r <= a1_f_r;
      b1_g_r <= b1_f_r;
    end
  end

  // Stage H: second products
  always_comb begin
    x1 = mulq(48'(m1_g_r), 48'(a1_g_r));
    x2 = mulq(48'(sx_g_r), 48'(q1_r));
    x3 = mulq(48'(m4_g_r), 48'(b1_g_r));
    x4 = mulq(48'(sy_g_r), 48'(q2_r));
    x5 = mulq(48'(pe_r), 48'(d_g_r));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      h1_r <= x1[35:0];
      h2_r <= x2[35:0];
      h3_r <= x3[35:0];
      h4_r <= x4[35:0];
      he_r <= x5[35:0];
    end
  end

  // Stage I: combine
  always_ff @(posedge clk) begin
    if (en[3]) begin
      poly_r.px <= 37'(h1_r) - 37'(h2_r);
      poly_r.py <= 37'(h3_r) + 37'(h4_r);
      poly_r.he <= 37'(he_r);
    end
  end

  assign poly = poly_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rafc_scale.sv -----
// Scaling by the material constant, axis products and the output register (five stages).
`default_nettype none

module rafc_scale import rafc_pkg::*; (
  input  logic               clk,
  input  logic [4:0]         en,
  input  logic               enabled,
  input  poly_t              poly,
  input  side_t              side_j,   // item entering stage J
  input  logic               energy_k, // item entering stage K is an energy item
  input  coef_t              coef_l,   // axes of the item entering stage L
  input  ctx_t               ctx_n,    // item entering the output stage
  output logic signed [47:0] field_x,
  output logic signed [47:0] field_y,
  output logic signed [47:0] field_z,
  output logic signed [47:0] energy
);

  logic signed [60:0] pxh_r, pxl_r, pyh_r, pyl_r;
  logic signed [55:0] fx2_r, fy2_r;
  logic signed [60:0] tfh_r [3];
  logic signed [60:0] tfl_r [3];
  logic signed [60:0] tgh_r [3];
  logic signed [60:0] tgl_r [3];
  logic signed [55:0] e_l_r, e_m_r;
  logic signed [55:0] tf_r [3];
  logic signed [55:0] tg_r [3];
  logic signed [47:0] fx_r, fy_r, fz_r, en_r;

  logic signed [36:0] xsel;
  logic signed [23:0] kh;
  logic signed [24:0] kl;
  logic signed [95:0] kx, ky;
  logic signed [65:0] qx, qy;
  logic signed [27:0] fxh, fyh;
  logic signed [28:0] fxl, fyl;
  logic signed [31:0] fa [3];
  logic signed [31:0] ga [3];
  logic signed [65:0] qf [3];
  logic signed [65:0] qg [3];
  logic signed [47:0] base [3];
  logic signed [57:0] fsum [3];

  // Stage J: split the constant, partial products
  always_comb begin
    xsel = side_j.ctx.is_energy ? poly.he : poly.px;
    kh   = side_j.coef.k[47:24];
    kl   = $signed({1'b0, side_j.coef.k[23:0]});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pxh_r <= 61'(kh) * 61'(xsel);
      pxl_r <= 61'(kl) * 61'(xsel);
      pyh_r <= 61'(kh) * 61'(poly.py);
      pyl_r <= 61'(kl) * 61'(poly.py);
    end
  end

  // Stage K: recombine; field items use 2k
  always_comb begin
    kx = (96'(pxh_r) <<< 24) + 96'(pxl_r);
    ky = (96'(pyh_r) <<< 24) + 96'(pyl_r);
    qx = energy_k ? q30(kx) : q30(kx <<< 1);
    qy = q30(ky <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fx2_r <= qx[55:0];
      fy2_r <= qy[55:0];
    end
  end

  // Stage L: partial products with the axis components
  always_comb begin
    fxh = fx2_r[55:28];
    fyh = fy2_r[55:28];
    fxl = $signed({1'b0, fx2_r[27:0]});
    fyl = $signed({1'b0, fy2_r[27:0]});
    fa[0] = coef_l.f_x;
    fa[1] = coef_l.f_y;
    fa[2] = coef_l.f_z;
    ga[0] = coef_l.g_x;
    ga[1] = coef_l.g_y;
    ga[2] = coef_l.g_z;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        tfh_r[i] <= 61'(fxh) * 61'(fa[i]);
        tfl_r[i] <= 61'(fxl) * 61'(fa[i]);
        tgh_r[i] <= 61'(fyh) * 61'(ga[i]);
        tgl_r[i] <= 61'(fyl) * 61'(ga[i]);
      end
      e_l_r <= fx2_r;
    end
  end

  // Stage M: recombine and rescale
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qf[i] = q30((96'(tfh_r[i]) <<< 28) + 96'(tfl_r[i]));
      qg[i] = q30((96'(tgh_r[i]) <<< 28) + 96'(tgl_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        tf_r[i] <= qf[i][55:0];
        tg_r[i] <= qg[i][55:0];
      end
      e_m_r <= e_l_r;
    end
  end

  // Stage N: add to the incoming field, saturate, select result
  always_comb begin
    base[0] = ctx_n.base_x;
    base[1] = ctx_n.base_y;
    base[2] = ctx_n.base_z;
    for (int i = 0; i < 3; i++) begin
      fsum[i] = 58'(base[i]) + 58'(tf_r[i]) + 58'(tg_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      if (ctx_n.is_energy) begin
        fx_r <= '0;
        fy_r <= '0;
        fz_r <= '0;
        en_r <= sat48(-58'(e_m_r));
      end else if (enabled) begin
        fx_r <= sat48(fsum[0]);
        fy_r <= sat48(fsum[1]);
        fz_r <= sat48(fsum[2]);
        en_r <= '0;
      end else begin
        fx_r <= base[0];
        fy_r <= base[1];
        fz_r <= base[2];
        en_r <= '0;
      end
    end
  end

  assign field_x = fx_r;
  assign field_y = fy_r;
  assign field_z = fz_r;
  assign energy  = en_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rotational_anisotropy_6_2_field_core.sv -----
// Top level of the rotational anisotropy field core.
`default_nettype none

// Sixth-order-theta, second-order-phi rotational anisotropy, one atom per item.
// Load items (req_type 0) write one coefficient of the per-material table in the
// cycle they are accepted and produce no result; field items (1) return the
// incoming field plus the anisotropy contribution (or the incoming field alone
// while enabled is 0), energy items (2) return the energy with zero fields.
// The datapath is a 14-stage pipeline: registered table read, twelve arithmetic
// stages, output register. An item can be accepted every cycle unless a result
// waiting at the output has filled every stage. Throughput is set by the output
// handshake alone: each stage advances when it is empty or its successor
// advances, so bubbles are filled while a result waits. A load followed by a
// compute item on the next cycle sees the new coefficient.
module rotational_anisotropy_6_2_field_core import rafc_pkg::*; #(
  parameter int MATERIALS = MATERIALS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  rafc_in_if.sink         in_ch,
  rafc_out_if.source      out_ch,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data
);

  logic [NS-1:0]      en;
  logic               in_compute;
  logic               in_fire;
  logic               enabled_r;
  ctx_t               ctx0_r;
  logic signed [31:0] spin_x_r, spin_y_r, spin_z_r;
  coef_t              coef0;
  side_t              side_s [NS-1];
  side_t              side_r [1:NS-2];
  proj_t              proj;
  poly_t              poly;

  assign in_compute = (in_ch.req_type == REQ_FIELD) || (in_ch.req_type == REQ_ENERGY);
  assign in_fire    = in_ch.valid && in_ch.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
    end else if (cfg_wr_en) begin
      enabled_r <= cfg_wr_data;
    end
  end

  rafc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_compute (in_compute),
    .out_ready  (out_ch.ready),
    .en         (en),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid)
  );

  rafc_table #(.MATERIALS(MATERIALS)) u_table (
    .clk      (clk),
    .wr_en    (in_fire && (in_ch.req_type == REQ_LOAD)),
    .rd_en    (en[0]),
    .material (in_ch.material),
    .slot     (in_ch.table_slot),
    .value    (in_ch.table_value),
    .coef     (coef0)
  );

  // Entry stage: item payload alongside the table read
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ctx0_r.is_energy <= in_ch.req_type == REQ_ENERGY;
      ctx0_r.base_x    <= in_ch.base_x;
      ctx0_r.base_y    <= in_ch.base_y;
      ctx0_r.base_z    <= in_ch.base_z;
      spin_x_r         <= in_ch.spin_x;
      spin_y_r         <= in_ch.spin_y;
      spin_z_r         <= in_ch.spin_z;
    end
  end

  // Side line: context and coefficients travel with each item
  always_comb begin
    side_s[0].ctx  = ctx0_r;
    side_s[0].coef = coef0;
    for (int i = 1; i < NS-1; i++) side_s[i] = side_r[i];
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i < NS-1; i++) begin
      if (en[i]) side_r[i] <= side_s[i-1];
    end
  end

  rafc_proj u_proj (
    .clk    (clk),
    .en     (en[4:1]),
    .spin_x (spin_x_r),
    .spin_y (spin_y_r),
    .spin_z (spin_z_r),
    .coef   (side_s[0].coef),
    .proj   (proj)
  );

  rafc_poly u_poly (
    .clk  (clk),
    .en   (en[8:5]),
    .proj (proj),
    .poly (poly)
  );

  rafc_scale u_scale (
    .clk      (clk),
    .en       (en[13:9]),
    .enabled  (enabled_r),
    .poly     (poly),
    .side_j   (side_s[8]),
    .energy_k (side_s[9].ctx.is_energy),
    .coef_l   (side_s[10].coef),
    .ctx_n    (side_s[12].ctx),
    .field_x  (out_ch.field_x),
    .field_y  (out_ch.field_y),
    .field_z  (out_ch.field_z),
    .energy   (out_ch.energy)
  );

  // A ready sink downstream must never back-pressure the input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output is ready");

  // Energy results carry zero fields
  a_energy_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.energy != 48'sd0) |->
      (out_ch.field_x == 48'sd0 && out_ch.field_y == 48'sd0 && out_ch.field_z == 48'sd0))
    else $error("energy result with nonzero field");

  // A waiting result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.field_x) && $stable(out_ch.field_y) &&
       $stable(out_ch.field_z) && $stable(out_ch.energy)))
    else $error("waiting result changed");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for the rotational anisotropy field core: directed and random items, checked by a predictor.
`timescale 1ns / 100ps

module testbench;
  import rafc_pkg::*;

  localparam longint Q_ONE = 64'sd1073741824;
  localparam longint CLAMP61 = 64'sd2305843009213693952;
  localparam longint K32_11 = 64'sd3123612579;
  localparam longint K16_11 = 64'sd1561806289;
  localparam longint K16_33 = 64'sd520602096;
  localparam longint LIM48_HI = 64'sd140737488355327;
  localparam longint LIM48_LO = -64'sd140737488355328;
  localparam int DRAIN_CYCLES = NS + 10;

  typedef struct {
    logic signed [47:0] fx;
    logic signed [47:0] fy;
    logic signed [47:0] fz;
    logic signed [47:0] en;
  } field_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  rafc_in_if req_ch();
  rafc_out_if res_ch();

  rotational_anisotropy_6_2_field_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch), .out_ch(res_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state: coefficient tables and the enable bit
  logic signed [31:0] axis_mem [0:6*MATERIALS_DEF-1];
  logic signed [47:0] k_mem [0:MATERIALS_DEF-1];
  logic               field_on;

  field_result_t pending_fields[$];
  int  error_count;
  int  hold_off_cycles;  // receiver stall requested by the pressure test
  bit  steady_ready;     // no random stalls on the result side

  // Clock
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // (a*b) >> 30, truncated toward zero, clamped to +-2^61
  function automatic longint mul_q30(input longint a, input longint b);
    logic signed [127:0] pa, pb, p, m;
    logic [127:0] r;
    pa = a; pb = b;
    p = pa * pb;
    m = (p < 0) ? -p : p;
    r = m >> 30;
    if (r > CLAMP61) r = CLAMP61;
    return (p < 0) ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [47:0] to48(input longint v);
    longint c;
    c = clip(v, LIM48_LO, LIM48_HI);
    return c[47:0];
  endfunction

  // Projection of the spin onto one axis, clamped to unit length
  function automatic longint dot_axis(input longint s[3], input int base_idx, input bit zero);
    longint acc;
    acc = 0;
    for (int i = 0; i < 3; i++)
      acc += mul_q30(s[i], zero ? 0 : longint'(axis_mem[base_idx + i]));
    return clip(acc, -Q_ONE, Q_ONE);
  endfunction

  // Expected result of one field or energy item
  function automatic field_result_t anisotropy_response(
      input logic [1:0] req, input logic [3:0] mat, input logic signed [31:0] spx,
      input logic signed [31:0] spy, input logic signed [31:0] spz,
      input logic signed [47:0] bx, input logic signed [47:0] by,
      input logic signed [47:0] bz);
    field_result_t r;
    longint s[3], b[3], f[3], g[3], out3[3];
    longint k, sx, sy, sx2, sy2, t, poly, e, px, py, fx2, fy2;
    bit zero;
    s[0] = spx; s[1] = spy; s[2] = spz;
    b[0] = bx; b[1] = by; b[2] = bz;
    zero = (mat >= MATERIALS_DEF);
    k = zero ? 0 : longint'(k_mem[mat]);
    for (int i = 0; i < 3; i++) begin
      f[i] = zero ? 0 : longint'(axis_mem[mat*6 + i]);
      g[i] = zero ? 0 : longint'(axis_mem[mat*6 + 3 + i]);
    end
    sx = dot_axis(s, mat*6, zero);
    sy = dot_axis(s, mat*6 + 3, zero);
    sx2 = mul_q30(sx, sx);
    sy2 = mul_q30(sy, sy);
    t = sx2 + sy2;
    r.fx = 0; r.fy = 0; r.fz = 0; r.en = 0;
    if (req == REQ_ENERGY) begin
      poly = mul_q30(t, t) - mul_q30(K16_11, t) + K16_33;
      e = mul_q30(k, mul_q30(poly, sx2 - sy2));
      r.en = to48(-e);
      return r;
    end
    if (!field_on) begin
      r.fx = bx; r.fy = by; r.fz = bz;
      return r;
    end
    px = mul_q30(mul_q30(sx, t), 3*sx2 - sy2) - mul_q30(sx, mul_q30(K32_11, sx2) - K16_33);
    py = mul_q30(mul_q30(sy, t), sx2 - 3*sy2) + mul_q30(sy, mul_q30(K32_11, sy2) - K16_33);
    px = clip(px, -CLAMP61, CLAMP61);
    py = clip(py, -CLAMP61, CLAMP61);
    fx2 = mul_q30(2*k, px);
    fy2 = mul_q30(2*k, py);
    for (int i = 0; i < 3; i++)
      out3[i] = b[i] + mul_q30(fx2, f[i]) + mul_q30(fy2, g[i]);
    r.fx = to48(out3[0]); r.fy = to48(out3[1]); r.fz = to48(out3[2]);
    return r;
  endfunction

  // Random gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one item and update the predictor when it is accepted
  task automatic send_item(input logic [1:0] req, input logic [3:0] mat,
                           input logic [2:0] slot, input logic signed [47:0] val,
                           input logic signed [31:0] spx, input logic signed [31:0] spy,
                           input logic signed [31:0] spz, input logic signed [47:0] bx,
                           input logic signed [47:0] by, input logic signed [47:0] bz,
                           input bit gaps);
    int gap;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.req_type = req; req_ch.material = mat;
    req_ch.table_slot = slot; req_ch.table_value = val;
    req_ch.spin_x = spx; req_ch.spin_y = spy; req_ch.spin_z = spz;
    req_ch.base_x = bx; req_ch.base_y = by; req_ch.base_z = bz;
    do @(posedge clk); while (!req_ch.ready);
    if (req == REQ_LOAD) begin
      if (mat < MATERIALS_DEF) begin
        if (slot < SLOT_AXES_END)
          axis_mem[mat*6 + slot] = 32'(clip(val, -64'sd2147483648, 64'sd2147483647));
        else if (slot == SLOT_CONST)
          k_mem[mat] = val;
      end
    end else if (req == REQ_FIELD || req == REQ_ENERGY) begin
      pending_fields.push_back(anisotropy_response(req, mat, spx, spy, spz, bx, by, bz));
    end
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  // Result side: random stalls, now and then a long one, plus a long hold when asked
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      res_ch.ready = 1'b0;
      hold_off_cycles--;
    end else if (steady_ready) begin
      res_ch.ready = 1'b1;
    end else if ($urandom_range(0, 99) < 70) begin
      res_ch.ready = 1'b1;
    end else begin
      res_ch.ready = 1'b0;
      if ($urandom_range(0, 19) == 0) hold_off_cycles = $urandom_range(10, 40);
    end
  end

  // Result checker
  always @(posedge clk) begin
    field_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_fields.size() == 0) begin
        $error("result with nothing expected");
        error_count++;
      end else begin
        want = pending_fields.pop_front();
        if (res_ch.field_x !== want.fx) begin
          $error("field_x expected %0d got %0d", want.fx, res_ch.field_x); error_count++;
        end
        if (res_ch.field_y !== want.fy) begin
          $error("field_y expected %0d got %0d", want.fy, res_ch.field_y); error_count++;
        end
        if (res_ch.field_z !== want.fz) begin
          $error("field_z expected %0d got %0d", want.fz, res_ch.field_z); error_count++;
        end
        if (res_ch.energy !== want.en) begin
          $error("energy expected %0d got %0d", want.en, res_ch.energy); error_count++;
        end
      end
    end
  end

  // Wait until every expected result is back, then let the pipeline settle
  task automatic drain();
    while (pending_fields.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_enable(input logic v);
    drain();
    cfg_wr_en = 1'b1; cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    field_on = v;
  endtask

  function automatic logic signed [31:0] rand_unit();
    return 32'(longint'($urandom_range(0, 32'h8000_0000)) - Q_ONE);
  endfunction

  function automatic logic signed [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic logic signed [47:0] rand_k();
    return ($urandom_range(0, 9) == 0) ? rand48()
         : 48'(longint'($urandom_range(0, 32'hffff_ffff)) * 256 - 64'sd549755813888);
  endfunction

  task automatic load_material(input logic [3:0] mat, input bit gaps);
    for (int sl = 0; sl < 6; sl++)
      send_item(REQ_LOAD, mat, 3'(sl), 48'(rand_unit()), 0, 0, 0, 0, 0, 0, gaps);
    send_item(REQ_LOAD, mat, SLOT_CONST, rand_k(), 0, 0, 0, 0, 0, 0, gaps);
  endtask

  task automatic random_compute(input bit gaps);
    logic [1:0] req;
    bit wild;
    req = ($urandom_range(0, 1) == 0) ? REQ_FIELD : REQ_ENERGY;
    wild = ($urandom_range(0, 7) == 0);
    send_item(req, 4'($urandom_range(0, 15)), 3'($urandom), rand48(),
              wild ? 32'($urandom) : rand_unit(), wild ? 32'($urandom) : rand_unit(),
              wild ? 32'($urandom) : rand_unit(), rand48(), rand48(), rand48(), gaps);
  endtask

  // Fill every table entry so no compute item reads an unwritten one
  task automatic test_table_load();
    for (int m = 0; m < MATERIALS_DEF; m++) load_material(4'(m), 1'b0);
  endtask

  // Extremes, saturation of axis loads, ignored codes and slots
  task automatic test_directed();
    send_item(REQ_LOAD, 4'd1, 3'd0, 48'sh7fff_ffff_ffff, 0, 0, 0, 0, 0, 0, 1'b0);
    send_item(REQ_LOAD, 4'd1, 3'd4, 48'sh8000_0000_0000, 0, 0, 0, 0, 0, 0, 1'b0);
    send_item(REQ_LOAD, 4'd1, SLOT_CONST, 48'sh7fff_ffff_ffff, 0, 0, 0, 0, 0, 0, 1'b0);
    send_item(REQ_LOAD, 4'd2, SLOT_CONST, 48'sh8000_0000_0000, 0, 0, 0, 0, 0, 0, 1'b0);
    send_item(REQ_LOAD, 4'd2, 3'd7, 48'sh1234_5678_9abc, 0, 0, 0, 0, 0, 0, 1'b0);
    send_item(2'd3, 4'd15, 3'd7, 48'sh7fff_ffff_ffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 48'sh7fff_ffff_ffff, 0, 0, 1'b0);
    for (int m = 1; m <= 2; m++) begin
      send_item(REQ_FIELD, 4'(m), 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                48'sh7fff_ffff_ffff, 48'sh8000_0000_0000, 0, 1'b0);
      send_item(REQ_FIELD, 4'(m), 0, 0, 32'h80000000, 32'h7fffffff, 0,
                48'sh8000_0000_0000, 48'sh7fff_ffff_ffff, 48'sh7fff_ffff_ffff, 1'b0);
      send_item(REQ_ENERGY, 4'(m), 0, 0, 32'h7fffffff, 0, 32'h80000000, 0, 0, 0, 1'b0);
      send_item(REQ_ENERGY, 4'(m), 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
      send_item(REQ_FIELD, 4'(m), 0, 0, 32'(Q_ONE), 0, 0, 0, 0, 0, 1'b0);
    end
    // load then use on the next cycle
    send_item(REQ_LOAD, 4'd3, SLOT_CONST, 48'sd4294967296, 0, 0, 0, 0, 0, 0, 1'b0);
    send_item(REQ_FIELD, 4'd3, 0, 0, 32'(Q_ONE), 0, 0, 0, 0, 0, 1'b0);
    send_item(REQ_ENERGY, 4'd3, 0, 0, 0, 32'(Q_ONE), 0, 0, 0, 0, 1'b0);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 6) begin
        if ($urandom_range(0, 3) == 0)
          send_item(REQ_LOAD, 4'($urandom), 3'($urandom), rand48(), 0, 0, 0, 0, 0, 0, 1'b1);
        else
          send_item(REQ_LOAD, 4'($urandom), 3'($urandom_range(0, 6)),
                    ($urandom_range(0, 1) ? 48'(rand_unit()) : rand_k()), 0, 0, 0, 0, 0, 0,
                    1'b1);
      end else if ($urandom_range(0, 99) < 3) begin
        send_item(2'd3, 4'($urandom), 3'($urandom), rand48(), 32'($urandom), 32'($urandom),
                  32'($urandom), rand48(), rand48(), rand48(), 1'b1);
      end else begin
        random_compute(1'b1);
      end
    end
  endtask

  // Long receiver hold while items keep coming, then a run with no stalls
  task automatic test_backpressure();
    hold_off_cycles = 200;
    for (int i = 0; i < 60; i++) random_compute(1'b0);
    drain();
    steady_ready = 1'b1;
    for (int i = 0; i < 60; i++) random_compute(1'b0);
    drain();
    steady_ready = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = 1'b0;
    req_ch.valid = 1'b0; req_ch.req_type = REQ_LOAD; req_ch.material = 0;
    req_ch.table_slot = 0; req_ch.table_value = 0;
    req_ch.spin_x = 0; req_ch.spin_y = 0; req_ch.spin_z = 0;
    req_ch.base_x = 0; req_ch.base_y = 0; req_ch.base_z = 0;
    res_ch.ready = 1'b0;
    error_count = 0; hold_off_cycles = 0; steady_ready = 1'b0; field_on = 1'b0;
    for (int i = 0; i < 6*MATERIALS_DEF; i++) axis_mem[i] = 0;
    for (int i = 0; i < MATERIALS_DEF; i++) k_mem[i] = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_table_load();
    test_directed();
    write_enable(1'b1);
    test_directed();
    test_random(700);
    write_enable(1'b0);
    test_random(300);
    write_enable(1'b1);
    test_backpressure();
    test_random(700);
    drain();

    if (error_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #16_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
